@@ rtl/core/pse_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix stack evaluator package
// Shared widths, token codes and the command/status bundles that join the
// controller and the datapath.
// ----------------------------------------------------------------------------
package pse_pkg;

  localparam int VALUE_BITS      = 32;
  localparam int FRAC_BITS       = 16;
  localparam int INT_BITS        = VALUE_BITS - FRAC_BITS;
  localparam int STACK_DEPTH_DEF = 16;

  // The multiply and divide magnitude register holds a full quotient.
  localparam int MAG_BITS  = VALUE_BITS + FRAC_BITS;
  localparam int DIV_STEPS = MAG_BITS;
  localparam int STEP_BITS = $clog2(DIV_STEPS + 1);

  localparam int REQ_BITS = 3;
  localparam int OP_BITS  = 4;

  localparam logic [REQ_BITS-1:0] REQ_NUMBER   = 3'd0;
  localparam logic [REQ_BITS-1:0] REQ_PROPERTY = 3'd1;
  localparam logic [REQ_BITS-1:0] REQ_BINARY   = 3'd2;
  localparam logic [REQ_BITS-1:0] REQ_NOT      = 3'd3;

  localparam logic [OP_BITS-1:0] OP_ADD    = 4'd0;
  localparam logic [OP_BITS-1:0] OP_SUB    = 4'd1;
  localparam logic [OP_BITS-1:0] OP_MUL    = 4'd2;
  localparam logic [OP_BITS-1:0] OP_DIV    = 4'd3;
  localparam logic [OP_BITS-1:0] OP_EQ     = 4'd4;
  localparam logic [OP_BITS-1:0] OP_NE     = 4'd5;
  localparam logic [OP_BITS-1:0] OP_LT     = 4'd6;
  localparam logic [OP_BITS-1:0] OP_GT     = 4'd7;
  localparam logic [OP_BITS-1:0] OP_LE     = 4'd8;
  localparam logic [OP_BITS-1:0] OP_GE     = 4'd9;
  localparam logic [OP_BITS-1:0] OP_AND    = 4'd10;
  localparam logic [OP_BITS-1:0] OP_OR     = 4'd11;
  localparam logic [OP_BITS-1:0] OP_XOR    = 4'd12;
  localparam logic [OP_BITS-1:0] OP_ASSIGN = 4'd13;

  localparam logic [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam logic [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
  localparam logic [VALUE_BITS-1:0] ONE_FIX = {{(INT_BITS-1){1'b0}}, 1'b1,
                                               {FRAC_BITS{1'b0}}};

  typedef struct packed {
    logic accept;    // token beat taken into the token register
    logic exec;      // decode and execute the held token
    logic div_step;  // one restoring-division step
    logic commit;    // saturate the multiply/divide magnitude onto the stack
    logic finish;    // load the result register and clear the stack
  } pse_cmd_t;

  typedef struct packed {
    logic is_mul;    // held token is a multiply
    logic is_div;    // held token is a divide with a nonzero divisor
    logic last;      // held token ends the expression
    logic div_last;  // the divider is on its final step
  } pse_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/pse_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Generic single-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

@@ rtl/core/pse_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix stack evaluator controller
// Sequences one token at a time through execute, divide and commit steps,
// and owns the result valid flag.
// ----------------------------------------------------------------------------
module pse_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  input  wire pse_pkg::pse_sts_t sts,
  output pse_pkg::pse_cmd_t     cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_COMMIT,
    ST_LAST
  } state_t;

  state_t state;
  logic   out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd          = '0;
    cmd.accept   = s_tvalid && s_tready;
    cmd.exec     = (state == ST_EXEC);
    cmd.div_step = (state == ST_DIV);
    cmd.commit   = (state == ST_COMMIT);
    cmd.finish   = (state == ST_LAST) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // The result register empties on a taken beat and refills on finish.
      if (cmd.finish) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (cmd.accept) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (sts.is_mul) begin
            state <= ST_COMMIT;
          end else if (sts.is_div) begin
            state <= ST_DIV;
          end else if (sts.last) begin
            state <= ST_LAST;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          if (sts.div_last) begin
            state <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          state <= sts.last ? ST_LAST : ST_IDLE;
        end
        ST_LAST: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/pse_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix stack evaluator datapath
// Top-of-stack register over a RAM for the lower entries, the ALU, a shared
// multiply/divide magnitude register with saturation, and sticky error flags.
// ----------------------------------------------------------------------------
module pse_dp #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire pse_pkg::pse_cmd_t                      cmd,
  output pse_pkg::pse_sts_t                           sts,
  input  wire logic [pse_pkg::REQ_BITS-1:0]           req_type,
  input  wire logic [pse_pkg::OP_BITS-1:0]            op_code,
  input  wire logic signed [pse_pkg::VALUE_BITS-1:0]  number_value,
  input  wire logic                                   last_token,
  output logic signed [pse_pkg::VALUE_BITS-1:0]       result_value,
  output logic                                        underflow_flag,
  output logic                                        overflow_flag,
  output logic                                        arith_error_flag
);

  localparam int VB = pse_pkg::VALUE_BITS;
  localparam int FB = pse_pkg::FRAC_BITS;
  localparam int IB = pse_pkg::INT_BITS;
  localparam int MB = pse_pkg::MAG_BITS;
  localparam int SB = pse_pkg::STEP_BITS;
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  // Integer part, truncated toward zero.
  function automatic logic [IB-1:0] int_part(input logic [VB-1:0] v);
    logic round_up;
    round_up = v[VB-1] & (|v[FB-1:0]);
    int_part = v[VB-1:FB] + {{(IB-1){1'b0}}, round_up};
  endfunction

  // Token register.
  logic [pse_pkg::REQ_BITS-1:0] tok_req;
  logic [pse_pkg::OP_BITS-1:0]  tok_op;
  logic [VB-1:0]                tok_val;
  logic                         tok_last;

  // Stack and flags.
  logic [VB-1:0] tos;
  logic [CW-1:0] count;
  logic          err_under;
  logic          err_over;
  logic          err_arith;

  // Multiply/divide unit.
  logic [MB-1:0] mag;
  logic [VB-1:0] rem;
  logic [VB-1:0] dvs;
  logic          neg;
  logic [SB-1:0] step_cnt;

  logic [AW-1:0] ram_wr_addr;
  logic [AW-1:0] ram_rd_addr;
  logic [VB-1:0] ram_rd_data;
  logic          ram_wr_en;
  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;

  logic          has1;
  logic          has2;
  logic          full;
  logic          is_push;
  logic          is_not;
  logic          is_binary;
  logic [VB-1:0] push_val;
  logic [VB-1:0] left;
  logic [VB-1:0] right;
  logic [VB-1:0] mag_l;
  logic [VB-1:0] mag_r;
  logic [2*VB-1:0] product;
  logic [VB:0]   sum;
  logic [VB:0]   diff;
  logic          lt;
  logic [IB-1:0] il;
  logic [IB-1:0] ir;
  logic [VB-1:0] alu_res;
  logic          alu_arith;
  logic [VB-1:0] not_res;

  logic [VB-1:0] lim;
  logic          mag_over;
  logic [VB-1:0] comm_res;

  logic [VB:0]   rem_sh;
  logic [VB:0]   rem_sub;
  logic          q_bit;

  assign cnt_m1      = count - CW'(1);
  assign cnt_m2      = count - CW'(2);
  assign ram_wr_addr = cnt_m1[AW-1:0];
  assign ram_rd_addr = cnt_m2[AW-1:0];

  pse_ram #(
    .WIDTH (VB),
    .DEPTH (STACK_DEPTH)
  ) u_stack_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (tos),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  assign has1      = (count != '0);
  assign has2      = (count >= CW'(2));
  assign full      = (count == CW'(STACK_DEPTH));
  assign is_push   = (tok_req == pse_pkg::REQ_NUMBER) || (tok_req == pse_pkg::REQ_PROPERTY);
  assign is_not    = (tok_req == pse_pkg::REQ_NOT);
  assign is_binary = (tok_req == pse_pkg::REQ_BINARY) && (tok_op <= pse_pkg::OP_ASSIGN);
  assign push_val  = (tok_req == pse_pkg::REQ_NUMBER) ? tok_val : pse_pkg::ONE_FIX;

  // The lower operand was read from RAM in the accept cycle.
  assign right = has1 ? tos : '0;
  assign left  = has2 ? ram_rd_data : '0;

  assign mag_l   = left[VB-1]  ? (~left + VB'(1))  : left;
  assign mag_r   = right[VB-1] ? (~right + VB'(1)) : right;
  assign product = mag_l * mag_r;

  assign sum  = {left[VB-1], left} + {right[VB-1], right};
  assign diff = {left[VB-1], left} - {right[VB-1], right};
  assign lt   = $signed(left) < $signed(right);
  assign il   = int_part(left);
  assign ir   = int_part(right);
  assign not_res = {~ir, {FB{1'b0}}};

  always_comb begin
    alu_res   = '0;
    alu_arith = 1'b0;
    unique case (tok_op)
      pse_pkg::OP_ADD: begin
        if (sum[VB] != sum[VB-1]) begin
          alu_arith = 1'b1;
          alu_res   = sum[VB] ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX;
        end else begin
          alu_res = sum[VB-1:0];
        end
      end
      pse_pkg::OP_SUB: begin
        if (diff[VB] != diff[VB-1]) begin
          alu_arith = 1'b1;
          alu_res   = diff[VB] ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX;
        end else begin
          alu_res = diff[VB-1:0];
        end
      end
      pse_pkg::OP_DIV: begin
        // Only division by zero completes here.
        alu_arith = 1'b1;
        if (left == '0) begin
          alu_res = '0;
        end else begin
          alu_res = left[VB-1] ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX;
        end
      end
      pse_pkg::OP_EQ:  alu_res = (left == right)     ? pse_pkg::ONE_FIX : '0;
      pse_pkg::OP_NE:  alu_res = (left != right)     ? pse_pkg::ONE_FIX : '0;
      pse_pkg::OP_LT:  alu_res = lt                  ? pse_pkg::ONE_FIX : '0;
      pse_pkg::OP_GT:  alu_res = (!lt && left != right) ? pse_pkg::ONE_FIX : '0;
      pse_pkg::OP_LE:  alu_res = (lt || left == right)  ? pse_pkg::ONE_FIX : '0;
      pse_pkg::OP_GE:  alu_res = !lt                 ? pse_pkg::ONE_FIX : '0;
      pse_pkg::OP_AND: alu_res = {il & ir, {FB{1'b0}}};
      pse_pkg::OP_OR:  alu_res = {il | ir, {FB{1'b0}}};
      pse_pkg::OP_XOR: alu_res = {il ^ ir, {FB{1'b0}}};
      default:         alu_res = '0;
    endcase
  end

  // A negative result may reach one step further than a positive one.
  assign lim      = neg ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX;
  assign mag_over = (|mag[MB-1:VB]) || (mag[VB-1:0] > lim);
  always_comb begin
    if (mag_over) begin
      comm_res = neg ? pse_pkg::VAL_MIN : pse_pkg::VAL_MAX;
    end else if (neg) begin
      comm_res = ~mag[VB-1:0] + VB'(1);
    end else begin
      comm_res = mag[VB-1:0];
    end
  end

  // Restoring division: the numerator shifts out of mag as quotient bits
  // shift in at the bottom.
  assign rem_sh  = {rem, mag[MB-1]};
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign q_bit   = (rem_sh >= {1'b0, dvs});

  assign ram_wr_en = cmd.exec && is_push && !full && has1;

  always_comb begin
    sts          = '0;
    sts.is_mul   = is_binary && (tok_op == pse_pkg::OP_MUL);
    sts.is_div   = is_binary && (tok_op == pse_pkg::OP_DIV) && (right != '0);
    sts.last     = tok_last;
    sts.div_last = (step_cnt == SB'(1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tos       <= '0;
      count     <= CW'(1);
      err_under <= 1'b0;
      err_over  <= 1'b0;
      err_arith <= 1'b0;
      step_cnt  <= '0;
    end else if (cmd.finish) begin
      tos       <= '0;
      count     <= CW'(1);
      err_under <= 1'b0;
      err_over  <= 1'b0;
      err_arith <= 1'b0;
    end else if (cmd.exec) begin
      if (is_push) begin
        if (full) begin
          err_over <= 1'b1;
        end else begin
          tos   <= push_val;
          count <= count + CW'(1);
        end
      end else if (is_not) begin
        tos <= not_res;
        if (!has1) begin
          err_under <= 1'b1;
          count     <= CW'(1);
        end
      end else if (is_binary) begin
        count <= has2 ? cnt_m1 : CW'(1);
        if (!has2) begin
          err_under <= 1'b1;
        end
        if (!sts.is_mul && !sts.is_div) begin
          tos <= alu_res;
          if (alu_arith) begin
            err_arith <= 1'b1;
          end
        end
        if (sts.is_div) begin
          step_cnt <= SB'(pse_pkg::DIV_STEPS);
        end
      end
    end else if (cmd.div_step) begin
      step_cnt <= step_cnt - SB'(1);
    end else if (cmd.commit) begin
      tos <= comm_res;
      if (mag_over) begin
        err_arith <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tok_req  <= req_type;
      tok_op   <= op_code;
      tok_val  <= number_value;
      tok_last <= last_token;
    end
    if (cmd.exec && sts.is_mul) begin
      mag <= product[2*VB-1:FB];
      neg <= left[VB-1] ^ right[VB-1];
    end else if (cmd.exec && sts.is_div) begin
      mag <= {mag_l, {FB{1'b0}}};
      dvs <= mag_r;
      rem <= '0;
      neg <= left[VB-1] ^ right[VB-1];
    end else if (cmd.div_step) begin
      mag <= {mag[MB-2:0], q_bit};
      rem <= q_bit ? rem_sub[VB-1:0] : rem_sh[VB-1:0];
    end
    if (cmd.finish) begin
      result_value     <= has1 ? tos : '0;
      underflow_flag   <= err_under | !has1;
      overflow_flag    <= err_over;
      arith_error_flag <= err_arith;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/postfix_stack_evaluator_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Postfix stack evaluator
// Evaluates a postfix token stream on a Q16.16 value stack and emits the top
// of the stack with sticky error flags at the end of each expression.
//
//   Channel   Dir  Payload                                   Beat ends
//   s_*       in   tuser: req_type, op_code; tdata: number   s_tlast = last token
//   m_*       out  tdata: result; tuser: under, over, arith  one beat per expression
//
// A token passes through the accept cycle, which also reads the entry below
// the top from the stack RAM, and an execute cycle. A multiply adds a commit
// step for saturation after the registered 32x32 product; a divide with a nonzero
// divisor adds steps of one-bit restoring division and then a commit step.
// A last token adds a step to load the result register, and waits there
// while a previous result has not been taken. Reset leaves a stack holding a
// single zero with all flags clear; there is no clearing pass.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_top #(
  parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  s_tvalid,
  output logic                                       s_tready,
  input  wire logic signed [pse_pkg::VALUE_BITS-1:0] s_tdata,  // number_value
  input  wire logic [6:0]                            s_tuser,  // req_type, op_code
  input  wire logic                                  s_tlast,  // last_token
  output logic                                       m_tvalid,
  input  wire logic                                  m_tready,
  output logic signed [pse_pkg::VALUE_BITS-1:0]      m_tdata,  // result_value
  output logic [2:0]                                 m_tuser   // underflow, overflow,
                                                               // arith_error
);

  pse_pkg::pse_cmd_t cmd;
  pse_pkg::pse_sts_t sts;

  pse_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  pse_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .sts              (sts),
    .req_type         (s_tuser[2:0]),
    .op_code          (s_tuser[6:3]),
    .number_value     (s_tdata),
    .last_token       (s_tlast),
    .result_value     (m_tdata),
    .underflow_flag   (m_tuser[0]),
    .overflow_flag    (m_tuser[1]),
    .arith_error_flag (m_tuser[2])
  );

`ifndef NO_ASSERTIONS
  // A token goes through its execute cycle before the next is taken.
  assert property (@(posedge clk) disable iff (rst) cmd.accept |=> !s_tready)
    else $error("token accepted without an execute cycle");

  // A result is never loaded over one that has not been taken.
  assert property (@(posedge clk) disable iff (rst)
                   cmd.finish |-> (!m_tvalid || m_tready))
    else $error("result register overwritten");

  assert property (@(posedge clk) disable iff (rst) cmd.finish |=> m_tvalid)
    else $error("finished expression did not raise result valid");

  // The divider only runs while no new token can enter.
  assert property (@(posedge clk) disable iff (rst) cmd.div_step |-> !s_tready)
    else $error("divider stepping while accepting tokens");
`endif

endmodule
`default_nettype wire
